// File: rtl/dle_stuffed_frame_builder_core_macros.svh
// Assertion macros shared by the DLE framer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DLE_STUFFED_FRAME_BUILDER_CORE_MACROS_SVH
`define DLE_STUFFED_FRAME_BUILDER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property held at every clock edge out of reset.
`define DSFB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dsfb assertion failed");
// Implication with the consequent in the same cycle.
`define DSFB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsfb assertion failed");
`else
`define DSFB_ASSERT(lbl, clk, rst_n, prop)
`define DSFB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/dsfb_pkg.sv
// Types and constants of the DLE stuffing framer.
// No dependencies; imported by every RTL module of the block.
package dsfb_pkg;

  localparam int unsigned MaxRun  = 13;
  localparam int unsigned RunIdxW = $clog2(MaxRun);

  localparam logic [7:0] Dle      = 8'h10;
  localparam logic [7:0] Stx      = 8'h7B;
  localparam logic [7:0] SumSeed  = 8'hEB;
  localparam logic [7:0] HdrA     = 8'h55;
  localparam logic [7:0] HdrB     = 8'h15;
  localparam logic [7:0] Etx      = 8'h03;
  localparam logic [7:0] LenBias  = 8'd6;
  localparam logic [6:0] EscLen   = 7'h0A;  // length whose biased value is DLE

  typedef enum logic {
    OP_BEGIN   = 1'b0,
    OP_PAYLOAD = 1'b1
  } dsfb_op_e;

  typedef struct packed {
    dsfb_op_e   op;
    logic [6:0] frame_length;
    logic [7:0] payload_byte;
  } dsfb_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_run;
    logic       end_of_frame;
  } dsfb_out_t;

  // Bytes caused by one input beat, emitted in index order.
  typedef struct packed {
    logic                            vld;
    logic [MaxRun-1:0][7:0]          bytes;
    logic [RunIdxW-1:0]              count;
    logic                            eof;   // run ends with a frame trailer
  } dsfb_run_t;

endpackage

// File: rtl/dle_stuffed_frame_builder_core.sv
// DLE byte-stuffing framer with checksum: top level.
// A beat's run is registered in the run buffer, then its bytes move in order into the output register.
// Throughput: one output byte per cycle unless out_ready_i stalls the output register; a beat holds
// the run buffer until all the bytes it causes are out (begin: 9, 10, 12 or 13, payload: 1, 2, 4 or 5,
// dropped payload: 0 bytes, only the handshake).
// Reset: rst_ni asynchronous, active low; clears frame state and both valid flags.
module dle_stuffed_frame_builder_core import dsfb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dsfb_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dsfb_out_t out_data_o
);

  // Two parts:
  //  - framer: holds in_frame / bytes_left / check_sum and, in the cycle
  //    of the input beat, builds the whole run of bytes that beat causes
  //    (header with optional length escape, payload with DLE doubling,
  //    trailer with the negated checksum).
  //  - emitter: registers the run, steps an index through it and feeds
  //    an output register, one byte per cycle while that register is free.
  // A new beat is taken in the same cycle the previous run's last byte
  // moves into the output register, so runs follow back to back.

  dsfb_run_t run;
  logic      take_ok;
  logic      accept;

  assign in_ready_o = take_ok;
  assign accept     = in_valid_i && take_ok;

  dsfb_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .run_o     (run)
  );

  // payload beats outside a frame are accepted but yield no run
  dsfb_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && run.vld),
    .run_i       (run),
    .take_ok_o   (take_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/dsfb_framer.sv
// Frame state and run builder: turns one input beat into a run of bytes.
// Depends on dsfb_pkg and the assertion macro header.
`include "dle_stuffed_frame_builder_core_macros.svh"
module dsfb_framer import dsfb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  dsfb_in_t  in_data_i,
  output dsfb_run_t run_o
);

  logic       in_frame_q, in_frame_d;
  logic [6:0] bytes_left_q, bytes_left_d;
  logic [7:0] check_sum_q, check_sum_d;

  logic [7:0]         len_b;
  logic [7:0]         lp6;
  logic               len_esc;
  logic               pb_esc;
  logic [7:0]         begin_sum;
  logic [7:0]         pay_sum;
  logic [6:0]         left_dec;
  logic               trail;
  logic [RunIdxW-1:0] p;

  always_comb begin
    len_b     = {1'b0, in_data_i.frame_length};
    lp6       = len_b + LenBias;
    len_esc   = (in_data_i.frame_length == EscLen);
    pb_esc    = (in_data_i.payload_byte == Dle);
    begin_sum = SumSeed + {in_data_i.frame_length, 1'b0};
    pay_sum   = check_sum_q + in_data_i.payload_byte;
    left_dec  = bytes_left_q - 7'd1;
    trail     = 1'b0;
    p         = '0;

    run_o        = '0;
    in_frame_d   = in_frame_q;
    bytes_left_d = bytes_left_q;
    check_sum_d  = check_sum_q;

    case (in_data_i.op)
      OP_BEGIN: begin
        trail         = (in_data_i.frame_length == 7'd0);
        p             = RunIdxW'(3) + RunIdxW'(len_esc);
        run_o.vld     = 1'b1;
        run_o.bytes[0] = Dle;
        run_o.bytes[1] = Stx;
        run_o.bytes[2] = lp6;
        if (len_esc) begin
          run_o.bytes[3] = Dle;
        end
        run_o.bytes[p]                  = len_b;
        run_o.bytes[p + RunIdxW'(1)]    = 8'h00;
        run_o.bytes[p + RunIdxW'(2)]    = 8'h00;
        run_o.bytes[p + RunIdxW'(3)]    = 8'h00;
        run_o.bytes[p + RunIdxW'(4)]    = HdrA;
        run_o.bytes[p + RunIdxW'(5)]    = HdrB;
        run_o.count                     = p + RunIdxW'(6);
        if (trail) begin
          run_o.bytes[p + RunIdxW'(6)] = 8'h00 - begin_sum;
          run_o.bytes[p + RunIdxW'(7)] = Dle;
          run_o.bytes[p + RunIdxW'(8)] = Etx;
          run_o.count                  = p + RunIdxW'(9);
          run_o.eof                    = 1'b1;
        end
        check_sum_d  = begin_sum;
        bytes_left_d = in_data_i.frame_length;
        in_frame_d   = !trail;
      end
      OP_PAYLOAD: begin
        if (in_frame_q) begin
          trail          = (left_dec == 7'd0);
          p              = RunIdxW'(1) + RunIdxW'(pb_esc);
          run_o.vld      = 1'b1;
          run_o.bytes[0] = in_data_i.payload_byte;
          if (pb_esc) begin
            run_o.bytes[1] = Dle;
          end
          run_o.count = p;
          if (trail) begin
            run_o.bytes[p]               = 8'h00 - pay_sum;
            run_o.bytes[p + RunIdxW'(1)] = Dle;
            run_o.bytes[p + RunIdxW'(2)] = Etx;
            run_o.count                  = p + RunIdxW'(3);
            run_o.eof                    = 1'b1;
          end
          check_sum_d  = pay_sum;
          bytes_left_d = trail ? 7'd0 : left_dec;
          in_frame_d   = !trail;
        end
      end
      default: begin
        run_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      bytes_left_q <= '0;
      check_sum_q  <= '0;
    end else if (accept_i) begin
      in_frame_q   <= in_frame_d;
      bytes_left_q <= bytes_left_d;
      check_sum_q  <= check_sum_d;
    end
  end

  // an open frame always still expects payload
  `DSFB_ASSERT_IMPL(a_open_has_left, clk_i, rst_ni, in_frame_q, bytes_left_q != 7'd0)
  `DSFB_ASSERT_IMPL(a_closed_no_left, clk_i, rst_ni, !in_frame_q, bytes_left_q == 7'd0)

endmodule

// File: rtl/dsfb_emitter.sv
// Run buffer and output register: walks a run one byte per cycle while the output register is free.
// Depends on dsfb_pkg and the assertion macro header.
`include "dle_stuffed_frame_builder_core_macros.svh"
module dsfb_emitter import dsfb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  dsfb_run_t run_i,
  output logic      take_ok_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dsfb_out_t out_data_o
);

  dsfb_run_t          run_q;
  logic               run_vld_q;
  logic [RunIdxW-1:0] idx_q;
  logic               out_vld_q;
  dsfb_out_t          out_q;

  logic out_free;
  logic adv;
  logic last;

  assign last      = (idx_q == (run_q.count - RunIdxW'(1)));
  assign out_free  = !out_vld_q || out_ready_i;
  assign adv       = run_vld_q && out_free;
  assign take_ok_o = !run_vld_q || (adv && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (load_i) begin
        run_vld_q <= 1'b1;
        idx_q     <= '0;
      end else if (adv) begin
        run_vld_q <= !last;
        idx_q     <= idx_q + RunIdxW'(1);
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= run_i;
    end
    if (adv) begin
      out_q.frame_byte   <= run_q.bytes[idx_q];
      out_q.last_of_run  <= last;
      out_q.end_of_frame <= last && run_q.eof;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `DSFB_ASSERT_IMPL(a_idx_in_run, clk_i, rst_ni, run_vld_q, idx_q < run_q.count)
  `DSFB_ASSERT_IMPL(a_load_when_free, clk_i, rst_ni, load_i, take_ok_o && run_i.count != '0)
  `DSFB_ASSERT_IMPL(a_eof_is_last_etx, clk_i, rst_ni, out_vld_q && out_q.end_of_frame, out_q.last_of_run && out_q.frame_byte == Etx)

endmodule
